### sv/assert_macros.svh
// assertion macros shared by the deframer rtl
// no dependencies; compiled away when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)

`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

### sv/stf_pkg.sv
// types and constants for the header/tail deframer
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package stf_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h53;
    localparam logic [7:0] HDR_SECOND  = 8'h59;
    localparam logic [7:0] TAIL_FIRST  = 8'h54;
    localparam logic [7:0] TAIL_SECOND = 8'h43;
    localparam logic [7:0] HDR_SUM     = 8'hAC;

    localparam int LEN_W = 11;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // byte request from the input register to the core
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } stf_byte_req_t;

    // one result item
    typedef struct packed {
        logic             is_end;
        logic [7:0]       data_byte;
        logic [1:0]       frame_status;
        logic [LEN_W-1:0] payload_length;
    } stf_result_t;

endpackage

### sv/stf_in_stage.sv
// input register of the deframer: holds one received byte for the core
// depends on stf_pkg
`timescale 1ns / 1ps

module stf_in_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            rx_byte,
    input  logic                  take,
    output stf_pkg::stf_byte_req_t req
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       load;

    // refill whenever the slot is empty or being consumed
    assign s_tready      = !in_valid_reg || take;
    assign load          = s_tvalid && s_tready;
    assign in_valid_next = load ? 1'b1 : (take ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    assign req.valid   = in_valid_reg;
    assign req.rx_byte = in_byte_reg;

endmodule

### sv/stf_deframe_core.sv
// deframer core: header hunt, two-byte hold, tail detect, sum check, overflow abort
// depends on stf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stf_deframe_core
#(
    parameter int MAX_PAYLOAD = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output stf_pkg::stf_result_t  res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic             in_frame_reg,   in_frame_next;
    logic             saw_first_reg,  saw_first_next;
    logic [1:0]       held_count_reg, held_count_next;
    logic [7:0]       held0_reg,      held0_next;
    logic [7:0]       held1_reg,      held1_next;
    logic [7:0]       sum_reg,        sum_next;
    logic [CNT_W-1:0] count_reg,      count_next;

    logic [7:0]                         newest;
    logic                               tail_hit;
    logic [CNT_W+stf_pkg::LEN_W-1:0]    count_wide;
    logic [stf_pkg::LEN_W-1:0]          count_len;

    assign newest     = (held_count_reg == stf_pkg::HELD_TWO) ? held1_reg : held0_reg;
    assign tail_hit   = (held_count_reg != stf_pkg::HELD_NONE)
                        && (rx_byte == stf_pkg::TAIL_SECOND)
                        && (newest == stf_pkg::TAIL_FIRST);
    assign count_wide = {{stf_pkg::LEN_W{1'b0}}, count_reg};
    assign count_len  = count_wide[stf_pkg::LEN_W-1:0];

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        saw_first_next  = saw_first_reg;
        held_count_next = held_count_reg;
        held0_next      = held0_reg;
        held1_next      = held1_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        res_valid       = 1'b0;
        res             = '0;
        if (take)
        begin
            if (!in_frame_reg)
            begin
                if (saw_first_reg && rx_byte == stf_pkg::HDR_SECOND)
                begin
                    in_frame_next   = 1'b1;
                    saw_first_next  = 1'b0;
                    held_count_next = stf_pkg::HELD_NONE;
                    sum_next        = stf_pkg::HDR_SUM;
                    count_next      = '0;
                end
                else
                begin
                    saw_first_next = (rx_byte == stf_pkg::HDR_FIRST);
                end
            end
            else if (tail_hit)
            begin
                res_valid           = 1'b1;
                res.is_end          = 1'b1;
                res.payload_length  = count_len;
                // under six frame bytes means nothing was released yet
                if (held_count_reg != stf_pkg::HELD_TWO || count_reg == '0)
                begin
                    res.frame_status = stf_pkg::ST_SHORT;
                end
                else if (sum_reg == held0_reg)
                begin
                    res.frame_status = stf_pkg::ST_OK;
                end
                else
                begin
                    res.frame_status = stf_pkg::ST_MISMATCH;
                end
                in_frame_next   = 1'b0;
                saw_first_next  = 1'b0;
                held_count_next = stf_pkg::HELD_NONE;
            end
            else if (held_count_reg == stf_pkg::HELD_NONE)
            begin
                held0_next      = rx_byte;
                held_count_next = stf_pkg::HELD_ONE;
            end
            else if (held_count_reg == stf_pkg::HELD_ONE)
            begin
                held1_next      = rx_byte;
                held_count_next = stf_pkg::HELD_TWO;
            end
            else if (count_reg >= CNT_MAX)
            begin
                res_valid          = 1'b1;
                res.is_end         = 1'b1;
                res.frame_status   = stf_pkg::ST_OVERFLOW;
                res.payload_length = count_len;
                in_frame_next      = 1'b0;
                saw_first_next     = 1'b0;
                held_count_next    = stf_pkg::HELD_NONE;
            end
            else
            begin
                // release the oldest held byte as payload
                res_valid     = 1'b1;
                res.data_byte = held0_reg;
                held0_next    = held1_reg;
                held1_next    = rx_byte;
                sum_next      = sum_reg + held0_reg;
                count_next    = count_reg + CNT_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            saw_first_reg  <= 1'b0;
            held_count_reg <= stf_pkg::HELD_NONE;
            sum_reg        <= stf_pkg::HDR_SUM;
            count_reg      <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            saw_first_reg  <= saw_first_next;
            held_count_reg <= held_count_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

    `ASSERT_IMPLY(a_result_in_frame, clk, rst_n, res_valid, in_frame_reg)
    `ASSERT_NEVER(a_held_count_range, clk, rst_n, held_count_reg == 2'd3)
    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CNT_MAX)
    `ASSERT_IMPLY(a_hunt_clears_hold, clk, rst_n, !in_frame_reg,
                  held_count_reg == stf_pkg::HELD_NONE)

endmodule

### sv/stf_out_skid.sv
// output register plus skid register for result items
// depends on stf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stf_out_skid
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  stf_pkg::stf_result_t push_item,
    output logic                 space,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output stf_pkg::stf_result_t m_item
);

    logic                 out_valid_reg,  out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    stf_pkg::stf_result_t out_item_reg,   out_item_next;
    stf_pkg::stf_result_t skid_item_reg,  skid_item_next;
    logic                 pop;

    assign pop   = out_valid_reg && m_tready;
    assign space = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_item_next  = push_item;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_item   = out_item_reg;

    `ASSERT_IMPLY(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, push, !skid_valid_reg)
    `ASSERT_IMPLY(a_skid_drains_first, clk, rst_n, skid_valid_reg && pop,
                  out_valid_next && !skid_valid_next)

endmodule

### sv/sync_tail_frame_deframer.sv
// top level of the header/tail frame deframer with 8-bit sum check
// depends on stf_pkg, stf_in_stage, stf_deframe_core, stf_out_skid
`timescale 1ns / 1ps
//
// usage
// - slave side: one received byte per request on s_tdata[7:0]; bytes outside a
//   frame are dropped, a frame opens on the pair 0x53 0x59 and closes on 0x54 0x43
// - master side: one result per request; m_tuser is is_end (0 payload byte,
//   1 end of frame); an end result carries frame_status and payload_length
// - the byte right before the tail is the checksum and is never released; the
//   two newest frame bytes are held back until the next byte arrives
// - status: ok, checksum mismatch, too short (under six frame bytes), or overflow
//   when a release would exceed MAX_PAYLOAD bytes (frame dropped, hunt restarts)
// - path: a byte that releases a result shows it on m_tvalid once it has passed
//   the input register, then the result register
// - throughput: one byte per cycle while the skid register is empty; each
//   byte takes one compare/add pass in the core, input to result register
// - stall: a skid register behind the result register lets one more result land;
//   s_tready then drops until the receiver takes a result, nothing is lost
// - reset: input, result and skid slots empty, header hunt, sum preset to 0xac
//
module sync_tail_frame_deframer
#(
    parameter int MAX_PAYLOAD = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] data_byte, [9:8] frame_status,
                                    // [20:10] payload_length, [23:21] zero
    output logic        m_tuser     // [0] is_end
);

    stf_pkg::stf_byte_req_t req;
    stf_pkg::stf_result_t   core_res;
    stf_pkg::stf_result_t   out_item;
    logic                   core_valid;
    logic                   space;
    logic                   take;

    // the core consumes the held byte only when a result slot is free
    assign take = req.valid && space;

    stf_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .rx_byte  (s_tdata),
        .take     (take),
        .req      (req)
    );

    stf_deframe_core
    #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    )
    u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (req.rx_byte),
        .res_valid (core_valid),
        .res       (core_res)
    );

    stf_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_valid),
        .push_item (core_res),
        .space     (space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_item    (out_item)
    );

    // pack result fields, lowest field first, padded to whole bytes
    assign m_tdata = {3'b000, out_item.payload_length, out_item.frame_status,
                      out_item.data_byte};
    assign m_tuser = out_item.is_end;

endmodule

### tb/sync_tail_frame_deframer_tb.sv
// self-checking testbench for the header/tail deframer with 8-bit sum check
// depends on stf_pkg and sync_tail_frame_deframer; drives bytes, predicts results
`timescale 1ns / 1ps

module sync_tail_frame_deframer_tb;

    localparam int MAX_PAYLOAD     = 1024;
    localparam int RAND_ITEMS      = 700;
    localparam int HDR_BYTES       = 2;
    localparam int MIN_FRAME_BYTES = 6;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_PRINTED     = 50;
    localparam int TIMEOUT_NS      = 5_000_000;

    // one byte waiting to be sent; drain holds it back until all results are in
    typedef struct {
        logic [7:0] rx;
        bit         drain;
    } rx_entry_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [23:0] m_tdata;
    wire         m_tuser;

    sync_tail_frame_deframer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------
    // predictor state: a private copy of the deframer
    // ------------------------------------------------------------------
    bit          in_frame_q;
    bit          hdr_first_seen;
    logic [7:0]  held [2];          // oldest first
    logic [1:0]  held_cnt;
    logic [7:0]  frame_sum;
    int unsigned released;

    stf_pkg::stf_result_t frame_results_due [$];
    rx_entry_t            rx_stream [$];

    int n_errors       = 0;
    int n_results      = 0;
    int n_payload_out  = 0;
    int n_end_status [4];
    int n_accepted     = 0;
    int n_frame_items  = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int cycle_cnt      = 0;

    function void restart_hunt();
        in_frame_q     = 1'b0;
        hdr_first_seen = 1'b0;
        held[0]        = 8'h00;
        held[1]        = 8'h00;
        held_cnt       = stf_pkg::HELD_NONE;
    endfunction

    // end-of-frame result carrying the count released so far
    function void push_frame_end(logic [1:0] status);
        stf_pkg::stf_result_t r;
        r                = '0;
        r.is_end         = 1'b1;
        r.frame_status   = status;
        r.payload_length = released[stf_pkg::LEN_W-1:0];
        frame_results_due.push_back(r);
    endfunction

    // advance the predicted deframer by one accepted byte
    function void deframe_rx_byte(logic [7:0] b);
        logic [7:0]           newest;
        logic [7:0]           rel;
        int unsigned          frame_len;
        stf_pkg::stf_result_t r;
        if (!in_frame_q)
        begin
            // hunting: a 0x53 arms the header, a following 0x59 opens the frame
            if (hdr_first_seen && b == stf_pkg::HDR_SECOND)
            begin
                restart_hunt();
                in_frame_q = 1'b1;
                frame_sum  = stf_pkg::HDR_SUM;
                released   = 0;
            end
            else
                hdr_first_seen = (b == stf_pkg::HDR_FIRST);
            return;
        end
        newest = (held_cnt >= stf_pkg::HELD_TWO) ? held[1] : held[0];
        // tail pair completes: the oldest held byte is the checksum
        if (held_cnt >= stf_pkg::HELD_ONE && b == stf_pkg::TAIL_SECOND
            && newest == stf_pkg::TAIL_FIRST)
        begin
            frame_len = HDR_BYTES + released + held_cnt + 1;
            if (frame_len < MIN_FRAME_BYTES || held_cnt < stf_pkg::HELD_TWO)
                push_frame_end(stf_pkg::ST_SHORT);
            else if (frame_sum == held[0])
                push_frame_end(stf_pkg::ST_OK);
            else
                push_frame_end(stf_pkg::ST_MISMATCH);
            restart_hunt();
            return;
        end
        if (held_cnt < stf_pkg::HELD_TWO)
        begin
            held[held_cnt] = b;
            held_cnt       = held_cnt + 1'b1;
            return;
        end
        // a release past the payload limit aborts the frame
        if (released >= MAX_PAYLOAD)
        begin
            push_frame_end(stf_pkg::ST_OVERFLOW);
            restart_hunt();
            return;
        end
        rel         = held[0];
        held[0]     = held[1];
        held[1]     = b;
        frame_sum   = frame_sum + rel;
        released    = released + 1;
        r           = '0;
        r.data_byte = rel;
        frame_results_due.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function void push_rx(logic [7:0] b, bit drain);
        rx_entry_t e;
        e.rx    = b;
        e.drain = drain;
        rx_stream.push_back(e);
    endfunction

    // payload content: header and tail bytes show up often, but no 0x54 so a
    // generated frame never closes early
    function logic [7:0] payload_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = stf_pkg::HDR_FIRST;
            1:       b = stf_pkg::HDR_SECOND;
            2:       b = stf_pkg::TAIL_SECOND;
            3:       b = 8'h00;
            4:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == stf_pkg::TAIL_FIRST)
            b = stf_pkg::TAIL_FIRST + 8'd1;
        return b;
    endfunction

    // header, n payload bytes, checksum (good or corrupted), tail
    function void add_frame(int n, bit good_cs, bit drain);
        logic [7:0] sum;
        logic [7:0] b;
        sum = stf_pkg::HDR_SUM;
        push_rx(stf_pkg::HDR_FIRST, drain);
        push_rx(stf_pkg::HDR_SECOND, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            b   = payload_byte();
            sum = sum + b;
            push_rx(b, 1'b0);
        end
        if (!good_cs)
            sum = sum ^ 8'($urandom_range(1, 255));
        push_rx(sum, 1'b0);
        push_rx(stf_pkg::TAIL_FIRST, 1'b0);
        push_rx(stf_pkg::TAIL_SECOND, 1'b0);
        n_frame_items += n + 5;
    endfunction

    // mostly short gaps, now and then a long one
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    task report_mismatch(input string what, input int unsigned got, input int unsigned want);
        if (n_errors < MAX_PRINTED)
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     n_results, what, got, want);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // driver: sends rx_stream, predicts each byte as its request is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                deframe_rx_byte(s_tdata);
                n_accepted++;
            end
            // free slot: either nothing is offered or the offer was just taken
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (rx_stream.size() > 0 &&
                         !(rx_stream[0].drain && frame_results_due.size() > 0))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_stream[0].rx;
                    rx_stream.pop_front();
                    // every 128 requests a stretch of back-to-back bytes
                    gap_left = (n_accepted % 128 < 32) ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each taken result against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        stf_pkg::stf_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_results_due.size() == 0)
                    report_mismatch("unexpected result, tdata", m_tdata, 0);
                else
                begin
                    want = frame_results_due.pop_front();
                    if (m_tuser !== want.is_end)
                        report_mismatch("is_end", m_tuser, want.is_end);
                    if (m_tdata[7:0] !== want.data_byte)
                        report_mismatch("data_byte", m_tdata[7:0], want.data_byte);
                    if (m_tdata[9:8] !== want.frame_status)
                        report_mismatch("frame_status", m_tdata[9:8], want.frame_status);
                    if (m_tdata[20:10] !== want.payload_length)
                        report_mismatch("payload_length", m_tdata[20:10],
                                        want.payload_length);
                    if (m_tdata[23:21] !== 3'b000)
                        report_mismatch("tdata padding", m_tdata[23:21], 0);
                    if (want.is_end)
                        n_end_status[want.frame_status]++;
                    else
                        n_payload_out++;
                end
                n_results++;
            end
            cycle_cnt++;
            // receiver stalls, with a recurring stall-free stretch set by cycle_cnt
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (cycle_cnt % 1000 >= 200)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int  kind;
        bit  drain;
        bit  first;
        foreach (n_end_status[i])
            n_end_status[i] = 0;

        // directed: noise with extreme values, then a repeated first header byte
        push_rx(8'h00, 1'b0);
        push_rx(8'hFF, 1'b0);
        push_rx(stf_pkg::HDR_FIRST, 1'b0);
        push_rx(stf_pkg::HDR_FIRST, 1'b0);
        push_rx(stf_pkg::HDR_SECOND, 1'b0);
        push_rx(8'h00, 1'b0);
        push_rx(8'hFF, 1'b0);
        push_rx(8'hAB, 1'b0);          // 0xac + 0x00 + 0xff
        push_rx(stf_pkg::TAIL_FIRST, 1'b0);
        push_rx(stf_pkg::TAIL_SECOND, 1'b0);
        // tail right after the header
        push_rx(stf_pkg::HDR_FIRST, 1'b0);
        push_rx(stf_pkg::HDR_SECOND, 1'b0);
        push_rx(stf_pkg::TAIL_FIRST, 1'b0);
        push_rx(stf_pkg::TAIL_SECOND, 1'b0);
        // one byte before the tail, still too short
        push_rx(stf_pkg::HDR_FIRST, 1'b0);
        push_rx(stf_pkg::HDR_SECOND, 1'b0);
        push_rx(8'hAA, 1'b0);
        push_rx(stf_pkg::TAIL_FIRST, 1'b0);
        push_rx(stf_pkg::TAIL_SECOND, 1'b0);
        // header bytes carried as payload
        push_rx(stf_pkg::HDR_FIRST, 1'b0);
        push_rx(stf_pkg::HDR_SECOND, 1'b0);
        push_rx(stf_pkg::HDR_FIRST, 1'b0);
        push_rx(stf_pkg::HDR_SECOND, 1'b0);
        push_rx(8'h58, 1'b0);          // 0xac + 0x53 + 0x59
        push_rx(stf_pkg::TAIL_FIRST, 1'b0);
        push_rx(stf_pkg::TAIL_SECOND, 1'b0);
        // checksum mismatch
        add_frame(3, 1'b0, 1'b0);

        // random: mostly well-formed frames, some short, noise and broken ones
        first = 1'b1;
        while (n_frame_items < RAND_ITEMS)
        begin
            kind  = $urandom_range(0, 99);
            drain = first || ($urandom_range(0, 19) == 0);
            first = 1'b0;
            if (kind < 65)
                add_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 60)
                                                      : $urandom_range(1, 12),
                          $urandom_range(0, 4) != 0, drain);
            else if (kind < 75)
            begin
                push_rx(stf_pkg::HDR_FIRST, drain);
                push_rx(stf_pkg::HDR_SECOND, 1'b0);
                if ($urandom_range(0, 1))
                    push_rx(payload_byte(), 1'b0);
                push_rx(stf_pkg::TAIL_FIRST, 1'b0);
                push_rx(stf_pkg::TAIL_SECOND, 1'b0);
                n_frame_items += 4;
            end
            else if (kind < 85)
            begin
                // noise between frames, heavy on the first header byte
                repeat ($urandom_range(1, 8))
                    push_rx($urandom_range(0, 2) == 0 ? stf_pkg::HDR_FIRST
                                                      : 8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                // header with no tail; the next sequence runs into this frame
                push_rx(stf_pkg::HDR_FIRST, drain);
                push_rx(stf_pkg::HDR_SECOND, 1'b0);
                repeat ($urandom_range(1, 10))
                    push_rx(payload_byte(), 1'b0);
                n_frame_items += 6;
            end
        end

        // close any open frame, then a short clean frame sent after a full drain
        push_rx(stf_pkg::TAIL_FIRST, 1'b0);
        push_rx(stf_pkg::TAIL_SECOND, 1'b0);
        add_frame(4, 1'b1, 1'b1);

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (rx_stream.size() != 0 || s_tvalid)
            @(posedge clk);
        while (frame_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d bytes, checked %0d results: %0d payload bytes", n_accepted,
                 n_results, n_payload_out);
        $display("frame ends: %0d ok, %0d mismatch, %0d too short, %0d overflow",
                 n_end_status[stf_pkg::ST_OK], n_end_status[stf_pkg::ST_MISMATCH],
                 n_end_status[stf_pkg::ST_SHORT], n_end_status[stf_pkg::ST_OVERFLOW]);
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results still expected", frame_results_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/stf_pkg.sv
sv/stf_in_stage.sv
sv/stf_deframe_core.sv
sv/stf_out_skid.sv
sv/sync_tail_frame_deframer.sv
tb/sync_tail_frame_deframer_tb.sv
